[rtl/psc_pkg.sv]
// shared constants, types and coefficient rom of the polynomial approximation unit
package psc_pkg;

	localparam int ARG_FRAC_BITS    = 30;
	localparam int RESULT_FRAC_BITS = 32;
	localparam int COEF_FRAC_BITS   = 40;

	localparam int X_W       = 32;
	localparam int MODE_W    = 3;
	localparam int OUT_W     = 40;
	localparam int NUM_CELLS = 7;
	localparam int CIDX_W    = 3;

	localparam int XC_SH   = COEF_FRAC_BITS - ARG_FRAC_BITS;
	localparam int XMAG_W  = X_W + XC_SH;
	localparam int SQ_W    = 2 * X_W;
	localparam int Z_SH    = 2 * ARG_FRAC_BITS - COEF_FRAC_BITS;
	localparam int VMAG_W  = COEF_FRAC_BITS + 3;
	localparam int TMAG_W  = COEF_FRAC_BITS + 4;
	localparam int SPLIT   = TMAG_W / 2;
	localparam int HI_W    = TMAG_W - SPLIT;
	localparam int PP_LO_W = SPLIT + VMAG_W;
	localparam int PP_HI_W = HI_W + VMAG_W;
	localparam int FULL_W  = TMAG_W + VMAG_W;
	localparam int P_W     = TMAG_W + 2;
	localparam int COEF_W  = COEF_FRAC_BITS + 2;
	localparam int RES_SH  = COEF_FRAC_BITS - RESULT_FRAC_BITS;
	localparam int RM_W    = TMAG_W - RES_SH + 1;
	localparam int D_SH    = COEF_FRAC_BITS - 24;

	localparam logic [63:0] CF_ONE = 64'd1 << COEF_FRAC_BITS;
	localparam logic [FULL_W-1:0] PROD_RND = FULL_W'(1) << (COEF_FRAC_BITS - 1);
	localparam logic [63:0] OUT_POS_LIM = (64'd1 << (OUT_W - 1)) - 64'd1;
	localparam logic [63:0] OUT_NEG_LIM = 64'd1 << (OUT_W - 1);
	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

	// reciprocal magnitudes rounded to nearest
	localparam logic [63:0] M_INV2 =
		CF_ONE / 64'd2 + (CF_ONE % 64'd2 + 64'd2 / 64'd2) / 64'd2;
	localparam logic [63:0] M_INV6 =
		CF_ONE / 64'd6 + (CF_ONE % 64'd6 + 64'd6 / 64'd2) / 64'd6;
	localparam logic [63:0] M_INV8 =
		CF_ONE / 64'd8 + (CF_ONE % 64'd8 + 64'd8 / 64'd2) / 64'd8;
	localparam logic [63:0] M_INV16 =
		CF_ONE / 64'd16 + (CF_ONE % 64'd16 + 64'd16 / 64'd2) / 64'd16;
	localparam logic [63:0] M_INV24 =
		CF_ONE / 64'd24 + (CF_ONE % 64'd24 + 64'd24 / 64'd2) / 64'd24;
	localparam logic [63:0] M_INV120 =
		CF_ONE / 64'd120 + (CF_ONE % 64'd120 + 64'd120 / 64'd2) / 64'd120;
	localparam logic [63:0] M_INV720 =
		CF_ONE / 64'd720 + (CF_ONE % 64'd720 + 64'd720 / 64'd2) / 64'd720;
	localparam logic [63:0] M_INV5040 =
		CF_ONE / 64'd5040 + (CF_ONE % 64'd5040 + 64'd5040 / 64'd2) / 64'd5040;
	localparam logic [63:0] M_INV40320 =
		CF_ONE / 64'd40320 + (CF_ONE % 64'd40320 + 64'd40320 / 64'd2) / 64'd40320;
	localparam logic [63:0] M_INV362880 =
		CF_ONE / 64'd362880 + (CF_ONE % 64'd362880 + 64'd362880 / 64'd2) / 64'd362880;
	localparam logic [63:0] M_INV3628800 =
		CF_ONE / 64'd3628800 + (CF_ONE % 64'd3628800 + 64'd3628800 / 64'd2) / 64'd3628800;
	localparam logic [63:0] M_INV479001600 =
		CF_ONE / 64'd479001600
		+ (CF_ONE % 64'd479001600 + 64'd479001600 / 64'd2) / 64'd479001600;

	typedef enum logic [MODE_W-1:0] {
		MODE_SIN7   = 3'd0,
		MODE_SIN9   = 3'd1,
		MODE_SQRT3  = 3'd2,
		MODE_COS6   = 3'd3,
		MODE_COS12  = 3'd4,
		MODE_DCOS12 = 3'd5
	} mode_t;

	typedef struct packed {
		logic                tneg;
		logic [TMAG_W-1:0]   tmag;
		logic                vneg;
		logic [VMAG_W-1:0]   vmag;
		logic                xneg;
		logic [XMAG_W-1:0]   xmag;
		logic [MODE_W-1:0]   mode;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} stage_t;

	function automatic logic signed [COEF_W-1:0] signed_coef(input logic neg,
			input logic [63:0] mag);
		logic signed [COEF_W-1:0] m;
		m = $signed(mag[COEF_W-1:0]);
		return neg ? -m : m;
	endfunction

	function automatic logic poly_in_z(input logic [MODE_W-1:0] mode);
		return mode_t'(mode) inside {MODE_SIN7, MODE_SIN9, MODE_COS6, MODE_COS12, MODE_DCOS12};
	endfunction

	function automatic logic poly_times_x(input logic [MODE_W-1:0] mode);
		return mode_t'(mode) inside {MODE_SIN7, MODE_SIN9};
	endfunction

	// horner coefficients, highest power first, padded with leading zeros to seven terms
	function automatic logic signed [COEF_W-1:0] coef_at(input logic [MODE_W-1:0] mode,
			input logic [CIDX_W-1:0] idx);
		logic signed [COEF_W-1:0] c;
		c = '0;
		case (mode_t'(mode))
			MODE_SIN7: begin
				case (idx)
					3'd3:    c = signed_coef(1'b1, M_INV5040);
					3'd4:    c = signed_coef(1'b0, M_INV120);
					3'd5:    c = signed_coef(1'b1, M_INV6);
					3'd6:    c = signed_coef(1'b0, CF_ONE);
					default: c = '0;
				endcase
			end
			MODE_SIN9: begin
				case (idx)
					3'd2:    c = signed_coef(1'b0, M_INV362880);
					3'd3:    c = signed_coef(1'b1, M_INV5040);
					3'd4:    c = signed_coef(1'b0, M_INV120);
					3'd5:    c = signed_coef(1'b1, M_INV6);
					3'd6:    c = signed_coef(1'b0, CF_ONE);
					default: c = '0;
				endcase
			end
			MODE_SQRT3: begin
				case (idx)
					3'd3:    c = signed_coef(1'b0, M_INV16);
					3'd4:    c = signed_coef(1'b1, M_INV8);
					3'd5:    c = signed_coef(1'b0, M_INV2);
					3'd6:    c = signed_coef(1'b0, CF_ONE);
					default: c = '0;
				endcase
			end
			MODE_COS6: begin
				case (idx)
					3'd3:    c = signed_coef(1'b1, M_INV720);
					3'd4:    c = signed_coef(1'b0, M_INV24);
					3'd5:    c = signed_coef(1'b1, M_INV2);
					3'd6:    c = signed_coef(1'b0, CF_ONE);
					default: c = '0;
				endcase
			end
			MODE_COS12: begin
				case (idx)
					3'd0:    c = signed_coef(1'b0, M_INV479001600);
					3'd1:    c = signed_coef(1'b1, M_INV3628800);
					3'd2:    c = signed_coef(1'b0, M_INV40320);
					3'd3:    c = signed_coef(1'b1, M_INV720);
					3'd4:    c = signed_coef(1'b0, M_INV24);
					3'd5:    c = signed_coef(1'b1, M_INV2);
					3'd6:    c = signed_coef(1'b0, CF_ONE);
					default: c = '0;
				endcase
			end
			MODE_DCOS12: begin
				case (idx)
					3'd0:    c = signed_coef(1'b1, 64'd345 << D_SH);
					3'd1:    c = signed_coef(1'b1, 64'd22 << D_SH);
					3'd2:    c = signed_coef(1'b0, 64'd401 << D_SH);
					3'd3:    c = signed_coef(1'b1, 64'd23309 << D_SH);
					3'd4:    c = signed_coef(1'b0, 64'd699046 << D_SH);
					3'd5:    c = signed_coef(1'b1, 64'd8388611 << D_SH);
					3'd6:    c = signed_coef(1'b0, 64'd16777214 << D_SH);
					default: c = '0;
				endcase
			end
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

[rtl/psc_prep.sv]
// argument front end: square of x, horner variable select and leading coefficient
module psc_prep (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid,
	output logic                          stall,
	input  logic signed [psc_pkg::X_W-1:0] x_value,
	input  logic [psc_pkg::MODE_W-1:0]    mode,
	output psc_pkg::stage_t               down,
	input  logic                          down_stall
);
	import psc_pkg::*;

	logic                    valid_s1, valid_s2;
	logic signed [X_W-1:0]   x_s1;
	logic [MODE_W-1:0]       mode_s1;
	logic [SQ_W-1:0]         sq_s1;
	item_t                   item_s2;
	logic                    en1, en2;
	logic signed [SQ_W-1:0]  sq_d;
	logic [X_W-1:0]          mx;
	logic [VMAG_W-1:0]       z;
	logic signed [COEF_W-1:0] c0;
	item_t                   item_d;

	assign en2   = !valid_s2 || !down_stall;
	assign en1   = !valid_s1 || en2;
	assign stall = !en1;

	assign sq_d = SQ_W'(x_value) * SQ_W'(x_value);

	always_comb begin
		mx = x_s1[X_W-1] ? X_W'(-x_s1) : X_W'(x_s1);
		z  = VMAG_W'(sq_s1 >> Z_SH) + VMAG_W'(sq_s1[Z_SH-1]);
		c0 = coef_at(mode_s1, CIDX_W'(0));
		item_d.mode = mode_s1;
		item_d.xneg = x_s1[X_W-1];
		item_d.xmag = {mx, {XC_SH{1'b0}}};
		if (poly_in_z(mode_s1)) begin
			item_d.vneg = 1'b0;
			item_d.vmag = z;
		end else begin
			item_d.vneg = x_s1[X_W-1];
			item_d.vmag = VMAG_W'(item_d.xmag);
		end
		item_d.tneg = c0[COEF_W-1];
		item_d.tmag = TMAG_W'($unsigned(c0[COEF_W-1] ? -c0 : c0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= valid;
			if (en2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			x_s1    <= x_value;
			mode_s1 <= mode;
			sq_s1   <= $unsigned(sq_d);
		end
		if (en2) item_s2 <= item_d;
	end

	assign down.valid = valid_s2;
	assign down.item  = item_s2;

endmodule

[rtl/psc_cell.sv]
// one horner cell: t * v rounded, plus coefficient, over three stages
module psc_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  psc_pkg::stage_t                  up,
	input  logic signed [psc_pkg::COEF_W-1:0] coef,
	output logic                             up_stall,
	output psc_pkg::stage_t                  down,
	input  logic                             down_stall
);
	import psc_pkg::*;

	logic                     valid_s1, valid_s2, valid_s3;
	item_t                    item_s1, item_s2, item_s3;
	logic signed [COEF_W-1:0] coef_s1, coef_s2;
	logic                     pneg_s1;
	logic [PP_LO_W-1:0]       pp_lo_s1;
	logic [PP_HI_W-1:0]       pp_hi_s1;
	logic signed [P_W-1:0]    prod_s2;
	logic                     en1, en2, en3;
	logic [FULL_W-1:0]        sum_b;
	logic [P_W-2:0]           pmag_b;
	logic signed [P_W-1:0]    prod_b;
	logic signed [P_W-1:0]    sum_c;
	logic signed [P_W-1:0]    abs_c;
	item_t                    item_c;

	assign en3      = !valid_s3 || !down_stall;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign up_stall = !en1;

	// partial products summed with round-half-away on the magnitude
	always_comb begin
		sum_b  = FULL_W'(pp_lo_s1) + (FULL_W'(pp_hi_s1) << SPLIT) + PROD_RND;
		pmag_b = sum_b[COEF_FRAC_BITS +: (P_W - 1)];
		prod_b = pneg_s1 ? -$signed({1'b0, pmag_b}) : $signed({1'b0, pmag_b});
	end

	always_comb begin
		sum_c       = prod_s2 + P_W'(coef_s2);
		abs_c       = sum_c[P_W-1] ? -sum_c : sum_c;
		item_c      = item_s2;
		item_c.tneg = sum_c[P_W-1];
		item_c.tmag = TMAG_W'($unsigned(abs_c));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= up.valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			item_s1  <= up.item;
			coef_s1  <= coef;
			pneg_s1  <= up.item.tneg ^ up.item.vneg;
			pp_lo_s1 <= PP_LO_W'(up.item.tmag[SPLIT-1:0]) * PP_LO_W'(up.item.vmag);
			pp_hi_s1 <= PP_HI_W'(up.item.tmag[TMAG_W-1:SPLIT]) * PP_HI_W'(up.item.vmag);
		end
		if (en2) begin
			item_s2 <= item_s1;
			coef_s2 <= coef_s1;
			prod_s2 <= prod_b;
		end
		if (en3) item_s3 <= item_c;
	end

	assign down.valid = valid_s3;
	assign down.item  = item_s3;

endmodule

[rtl/poly_sin_cos_sqrt_approx_unit.sv]
// top level: polynomial sine, cosine and sqrt(1+x) approximation pipeline
//
// Usage:
//   arg channel (arg_valid / arg_stall) takes x_value (Q2.30) and mode; a
//   transaction happens on a rising edge with arg_valid high and arg_stall low.
//   res channel (res_valid / res_stall) returns approx_value (Q8.32) and the
//   saturated flag, one result per argument, in argument order.
//   The path runs through the front end (square of x), the 7 horner cells
//   (multiply, round, add coefficient) and the output register. Throughput is
//   one transaction per cycle while res_stall stays low; every mode runs through
//   all cells, shorter polynomials enter with leading zero coefficients.
//   Reset clears all valid bits; the pipeline is empty and ready afterwards.
//   While res_stall is high, the result holds and each stage holds its item
//   only when the stage after it is full, so bubbles close up and arguments
//   keep being taken until every stage is occupied; then arg_stall rises.
//   Modes 6 and 7 return zero with the flag clear.
module poly_sin_cos_sqrt_approx_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              arg_valid,
	output logic                              arg_stall,
	input  logic signed [psc_pkg::X_W-1:0]    x_value,
	input  logic [psc_pkg::MODE_W-1:0]        mode,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic signed [psc_pkg::OUT_W-1:0]  approx_value,
	output logic                              saturated
);
	import psc_pkg::*;

	stage_t                   chain [NUM_CELLS+1];
	logic                     chain_stall [NUM_CELLS+1];
	stage_t                   last_in;
	logic                     en_o;
	logic [RM_W-1:0]          rm;
	logic signed [RM_W:0]     rs;
	logic                     tneg;
	logic                     over;
	logic signed [OUT_W-1:0]  approx_d;
	logic                     res_valid_q;
	logic signed [OUT_W-1:0]  approx_q;
	logic                     sat_q;

	psc_prep u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (arg_valid),
		.stall      (arg_stall),
		.x_value    (x_value),
		.mode       (mode),
		.down       (chain[0]),
		.down_stall (chain_stall[0])
	);

	// last cell multiplies by x for sine, by one otherwise
	always_comb begin
		last_in = chain[NUM_CELLS-1];
		if (poly_times_x(last_in.item.mode)) begin
			last_in.item.vneg = last_in.item.xneg;
			last_in.item.vmag = VMAG_W'(last_in.item.xmag);
		end else begin
			last_in.item.vneg = 1'b0;
			last_in.item.vmag = VMAG_W'(CF_ONE);
		end
	end

	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		psc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.up         ((k == NUM_CELLS - 1) ? last_in : chain[k]),
			.coef       (coef_at(chain[k].item.mode, CIDX_W'(k + 1))),
			.up_stall   (chain_stall[k]),
			.down       (chain[k+1]),
			.down_stall (chain_stall[k+1])
		);
	end

	assign en_o                   = !res_valid_q || !res_stall;
	assign chain_stall[NUM_CELLS] = !en_o;

	// rescale to result fraction bits and saturate
	always_comb begin
		tneg = chain[NUM_CELLS].item.tneg;
		rm   = RM_W'(chain[NUM_CELLS].item.tmag >> RES_SH)
		     + RM_W'(chain[NUM_CELLS].item.tmag[RES_SH-1]);
		rs   = tneg ? -$signed({1'b0, rm}) : $signed({1'b0, rm});
		over = tneg ? (64'(rm) > OUT_NEG_LIM) : (64'(rm) > OUT_POS_LIM);
		if (over) begin
			approx_d = tneg ? OUT_MIN : OUT_MAX;
		end else begin
			approx_d = OUT_W'(rs);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en_o) begin
			res_valid_q <= chain[NUM_CELLS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_o) begin
			approx_q <= approx_d;
			sat_q    <= over;
		end
	end

	assign res_valid    = res_valid_q;
	assign approx_value = approx_q;
	assign saturated    = sat_q;

endmodule

[rtl/psc_port_checker.sv]
// port-level checks of the approximation unit, bound to its top level
module psc_port_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             arg_stall,
	input logic                             res_valid,
	input logic                             res_stall,
	input logic signed [psc_pkg::OUT_W-1:0] approx_value,
	input logic                             saturated
);
	import psc_pkg::*;

	a_res_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result withdrawn while stalled");

	a_res_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(approx_value) && $stable(saturated))
		else $error("result changed while stalled");

	a_sat_clipped: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && saturated |-> (approx_value == OUT_MAX || approx_value == OUT_MIN))
		else $error("saturated flag without a clipped value");

	a_no_stall_free: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_valid && res_stall) |-> !arg_stall)
		else $error("argument stalled while results drain freely");

endmodule

bind poly_sin_cos_sqrt_approx_unit psc_port_checker u_psc_port_checker (.*);

[dv/poly_approx_checker.sv]
// result checker for the polynomial approximation unit: predicts every transaction and compares
`timescale 1ns / 100ps
module poly_approx_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              arg_valid,
	input  logic                              arg_stall,
	input  logic signed [psc_pkg::X_W-1:0]    x_value,
	input  logic [psc_pkg::MODE_W-1:0]        mode,
	input  logic                              res_valid,
	input  logic                              res_stall,
	input  logic signed [psc_pkg::OUT_W-1:0]  approx_value,
	input  logic                              saturated,
	output int                                mismatch_count,
	output int                                pending
);
	import psc_pkg::*;

	localparam logic [63:0] MAG_CAP    = 64'd1 << 62;
	localparam logic [63:0] DYADIC_DEN = 64'd1 << 24;
	localparam int          NUM_MODES  = MODE_DCOS12 + 1;
	localparam int          PRINT_MAX  = 40;

	typedef struct {
		logic signed [OUT_W-1:0] value;
		logic                    sat;
		logic [X_W-1:0]          x;
		logic [MODE_W-1:0]       m;
	} approx_t;

	approx_t expected_q[$];
	approx_t oldest, fresh;
	longint  horner_coef[NUM_MODES][NUM_CELLS];
	int      horner_len[NUM_MODES];

	function automatic logic [63:0] mag(input longint v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint from_mag(input logic [63:0] m, input logic neg);
		if (m > MAG_CAP) begin
			m = MAG_CAP;
		end
		return neg ? -longint'(m) : longint'(m);
	endfunction

	// drop s fraction bits, round half away from zero
	function automatic longint round_shift(input longint v, input int s);
		logic [63:0] m;
		m = mag(v);
		m = (m >> s) + ((m >> (s - 1)) & 64'd1);
		return from_mag(m, v < 0);
	endfunction

	function automatic longint fixed_mul(input longint a, input longint b);
		logic [127:0] p;
		logic [63:0]  m;
		p = 128'(mag(a)) * 128'(mag(b)) + (128'd1 << (COEF_FRAC_BITS - 1));
		if ((p >> (64 + COEF_FRAC_BITS)) != 0) begin
			m = MAG_CAP;
		end else begin
			m = p[COEF_FRAC_BITS +: 64];
		end
		return from_mag(m, (a < 0) != (b < 0));
	endfunction

	function automatic longint rom_coef(input int num, input logic [63:0] den);
		logic [63:0] unit, n, q, r, m;
		unit = 64'd1 << COEF_FRAC_BITS;
		n = (num < 0) ? 64'(-num) : 64'(num);
		q = unit / den;
		r = unit % den;
		m = n * q + (n * r + den / 2) / den;
		return (num < 0) ? -longint'(m) : longint'(m);
	endfunction

	task automatic put_term(input mode_t m, input int k, input int num, input logic [63:0] den);
		horner_coef[m][k] = rom_coef(num, den);
		horner_len[m] = k + 1;
	endtask

	initial begin
		mismatch_count = 0;
		put_term(MODE_SIN7, 0, -1, 5040);
		put_term(MODE_SIN7, 1, 1, 120);
		put_term(MODE_SIN7, 2, -1, 6);
		put_term(MODE_SIN7, 3, 1, 1);
		put_term(MODE_SIN9, 0, 1, 362880);
		put_term(MODE_SIN9, 1, -1, 5040);
		put_term(MODE_SIN9, 2, 1, 120);
		put_term(MODE_SIN9, 3, -1, 6);
		put_term(MODE_SIN9, 4, 1, 1);
		put_term(MODE_SQRT3, 0, 1, 16);
		put_term(MODE_SQRT3, 1, -1, 8);
		put_term(MODE_SQRT3, 2, 1, 2);
		put_term(MODE_SQRT3, 3, 1, 1);
		put_term(MODE_COS6, 0, -1, 720);
		put_term(MODE_COS6, 1, 1, 24);
		put_term(MODE_COS6, 2, -1, 2);
		put_term(MODE_COS6, 3, 1, 1);
		put_term(MODE_COS12, 0, 1, 479001600);
		put_term(MODE_COS12, 1, -1, 3628800);
		put_term(MODE_COS12, 2, 1, 40320);
		put_term(MODE_COS12, 3, -1, 720);
		put_term(MODE_COS12, 4, 1, 24);
		put_term(MODE_COS12, 5, -1, 2);
		put_term(MODE_COS12, 6, 1, 1);
		put_term(MODE_DCOS12, 0, -345, DYADIC_DEN);
		put_term(MODE_DCOS12, 1, -22, DYADIC_DEN);
		put_term(MODE_DCOS12, 2, 401, DYADIC_DEN);
		put_term(MODE_DCOS12, 3, -23309, DYADIC_DEN);
		put_term(MODE_DCOS12, 4, 699046, DYADIC_DEN);
		put_term(MODE_DCOS12, 5, -8388611, DYADIC_DEN);
		put_term(MODE_DCOS12, 6, 16777214, DYADIC_DEN);
	end

	function automatic void predict_approx(input logic signed [X_W-1:0] x,
			input logic [MODE_W-1:0] m, output logic signed [OUT_W-1:0] value,
			output logic sat);
		longint      xs, xc, v, t, s, r;
		logic [63:0] mx;
		value = '0;
		sat = 1'b0;
		if (m > MODE_DCOS12) begin
			return;
		end
		xs = longint'(x);
		xc = xs * (longint'(1) << (COEF_FRAC_BITS - ARG_FRAC_BITS));
		if (m != MODE_SQRT3) begin
			mx = mag(xs);
			v = round_shift(longint'(mx * mx), 2 * ARG_FRAC_BITS - COEF_FRAC_BITS);
		end else begin
			v = xc;
		end
		t = horner_coef[m][0];
		for (int k = 1; k < horner_len[m]; k++) begin
			s = fixed_mul(t, v) + horner_coef[m][k];
			t = from_mag(mag(s), s < 0);
		end
		if (m == MODE_SIN7 || m == MODE_SIN9) begin
			t = fixed_mul(t, xc);
		end
		r = round_shift(t, COEF_FRAC_BITS - RESULT_FRAC_BITS);
		if (r > longint'(OUT_MAX)) begin
			r = longint'(OUT_MAX);
			sat = 1'b1;
		end
		if (r < longint'(OUT_MIN)) begin
			r = longint'(OUT_MIN);
			sat = 1'b1;
		end
		value = OUT_W'(r);
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_MAX) begin
			$display("mismatch at %0t: %s", $time, msg);
		end
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_q.size() == 0) begin
					report_mismatch($sformatf("result %h sat %b with no transaction pending",
						approx_value, saturated));
				end else begin
					oldest = expected_q.pop_front();
					if (approx_value !== oldest.value) begin
						report_mismatch($sformatf("x %h mode %0d: approx_value %h, expected %h",
							oldest.x, oldest.m, approx_value, oldest.value));
					end
					if (saturated !== oldest.sat) begin
						report_mismatch($sformatf("x %h mode %0d: saturated %b, expected %b",
							oldest.x, oldest.m, saturated, oldest.sat));
					end
				end
			end
			if (arg_valid && !arg_stall) begin
				fresh.x = x_value;
				fresh.m = mode;
				predict_approx(x_value, mode, fresh.value, fresh.sat);
				expected_q.push_back(fresh);
			end
			pending <= expected_q.size();
		end
	end

endmodule

[dv/tb_poly_sin_cos_sqrt_approx_unit.sv]
// testbench top for the polynomial approximation unit: stimulus, idling and verdict
`timescale 1ns / 100ps
module tb_poly_sin_cos_sqrt_approx_unit;
	import psc_pkg::*;

	localparam logic [MODE_W-1:0]    MODE_SPARE_LO = 3'd6;
	localparam logic [MODE_W-1:0]    MODE_SPARE_HI = 3'd7;
	localparam logic signed [X_W-1:0] X_MIN        = 32'sh8000_0000;
	localparam logic signed [X_W-1:0] X_MAX        = 32'sh7fff_ffff;
	localparam int RANDOM_ARGS  = 1750;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 400000;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    arg_valid = 1'b0;
	logic                    arg_stall;
	logic signed [X_W-1:0]   x_value = '0;
	logic [MODE_W-1:0]       mode = '0;
	logic                    res_valid;
	logic                    res_stall = 1'b0;
	logic signed [OUT_W-1:0] approx_value;
	logic                    saturated;
	int                      mismatches;
	int                      pending;
	int                      cycle_count = 0;
	int                      burst_left = 0;
	stall_style_t            rx_style = STALL_NONE;
	int                      rx_span = 0;
	int                      rx_tick = 0;

	always #5 clk = ~clk;

	poly_sin_cos_sqrt_approx_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.arg_valid    (arg_valid),
		.arg_stall    (arg_stall),
		.x_value      (x_value),
		.mode         (mode),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.approx_value (approx_value),
		.saturated    (saturated)
	);

	poly_approx_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.arg_valid      (arg_valid),
		.arg_stall      (arg_stall),
		.x_value        (x_value),
		.mode           (mode),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.approx_value   (approx_value),
		.saturated      (saturated),
		.mismatch_count (mismatches),
		.pending        (pending)
	);

	// receiver back-pressure, switching to a randomly chosen style after each random span
	always @(negedge clk) begin
		if (rx_span == 0) begin
			rx_style = stall_style_t'($urandom_range(STALL_NONE, STALL_PERIODIC));
			rx_span = $urandom_range(20, 300);
		end
		rx_span--;
		rx_tick++;
		case (rx_style)
			STALL_NONE:  res_stall <= 1'b0;
			STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
			default:     res_stall <= ((rx_tick % 7) < 3);
		endcase
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic send_arg(input logic [X_W-1:0] x, input logic [MODE_W-1:0] m, input int gap);
		if (gap > 0) begin
			arg_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		arg_valid <= 1'b1;
		x_value <= x;
		mode <= m;
		do @(posedge clk); while (arg_stall);
		@(negedge clk);
	endtask

	task automatic drain_results();
		arg_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	function automatic logic [X_W-1:0] random_arg();
		logic [X_W-1:0] x;
		case ($urandom_range(0, 3))
			0: begin
				x = $urandom >> $urandom_range(1, X_W - 1);
				if ($urandom_range(0, 1) == 1) begin
					x = -x;
				end
			end
			1: x = ($urandom_range(0, 1) == 1) ? X_MAX - $urandom_range(0, 255)
				: X_MIN + $urandom_range(0, 255);
			default: x = $urandom;
		endcase
		return x;
	endfunction

	initial begin
		int                gap;
		logic [MODE_W-1:0] m;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// argument extremes in every mode, the unused modes included
		for (int d = 0; d <= MODE_SPARE_HI; d++) begin
			send_arg(X_MIN, MODE_W'(d), 0);
			send_arg(X_MAX, MODE_W'(d), 0);
		end
		send_arg('0, MODE_SIN9, 0);
		send_arg(32'sh0000_0001, MODE_SQRT3, 0);
		send_arg(-32'sd1, MODE_COS6, 0);
		send_arg(32'sh4000_0000, MODE_COS12, 0);
		send_arg(32'shc000_0000, MODE_DCOS12, 0);
		send_arg(32'sh2000_0000, MODE_SIN7, 0);
		drain_results();

		for (int i = 0; i < RANDOM_ARGS; i++) begin
			if (i == RANDOM_ARGS / 2) begin
				drain_results();
			end
			gap = 0;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 48);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			end
			burst_left--;
			if ($urandom_range(0, 15) == 0) begin
				m = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
			end else begin
				m = MODE_W'($urandom_range(MODE_SIN7, MODE_DCOS12));
			end
			send_arg(random_arg(), m, gap);
		end
		drain_results();
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
